>>> sv/buddy_allocator_tree_assert.svh
// Assertion macros for the buddy allocator. The including module supplies
// i_clk and i_rst_n; checks are off while reset is held.
`ifndef BUDDY_ALLOCATOR_TREE_ASSERT_SVH
`define BUDDY_ALLOCATOR_TREE_ASSERT_SVH

// Same-cycle implication.
`define BAT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BAT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/buddy_pkg.sv
package buddy_pkg;

    // Sequencer states of the allocator.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_SIZE,
        S_ROOT,
        S_DOWN,
        S_MARK,
        S_FUP,
        S_UP,
        S_DONE
    } t_state;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_BAD_SIZE = 2'd1;
    localparam t_status ST_FULL     = 2'd2;
    localparam t_status ST_RANGE    = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

endpackage

>>> sv/buddy_allocator_tree.sv
// Buddy allocator over TOTAL_BLOCKS blocks of 2**BLOCK_SIZE_EXP bytes each.
// The input channel (i_in_valid / o_in_stall) carries one beat per request:
// an allocate with a byte count or a free with an address. The output channel
// (o_out_valid / i_out_stall) returns exactly one beat per request, a status
// and, for a successful allocate, the granted address.
// The user must write the base address register with i_base_address_we only
// while idle; the block itself does not enforce it. One request at a time runs
// through a small sequencer around a single tree memory, one node read and one
// node write per cycle. An allocate rounds its block count up to a power of
// two, checks the root, walks down one level at a time to a node of that size,
// marks it used and updates its ancestors on the way back up. A free climbs
// from its leaf to the first used node, marks it free and merges buddies on
// the way up; if no used node covers it, it ends at the root. A zero, oversize
// or out-of-range request ends right after the checks, a full region after
// the root read. The next beat is taken in the cycle after a result is loaded.
// After reset the block runs a clearing pass that writes every node's span;
// o_in_stall stays high throughout it. A finished result sits in the output
// register; the next request is taken while it waits. If the receiver
// stalls, the following result is held in the sequencer until the output
// register frees up.
module buddy_allocator_tree #(
    parameter int TOTAL_BLOCKS   = 256,
    parameter int BLOCK_SIZE_EXP = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_base_address_we,
    input  logic [63:0]        i_base_address,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_operation,
    input  logic [31:0]        i_request_bytes,
    input  logic [63:0]        i_free_address,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output buddy_pkg::t_status o_status,
    output logic [63:0]        o_granted_address
);
    import buddy_pkg::*;

    // Tree geometry. Node 0 is the root; children of node i are 2i+1, 2i+2.
    localparam int LOG_N = $clog2(TOTAL_BLOCKS);
    localparam int VAL_W = LOG_N + 1;
    localparam int IDX_W = LOG_N + 1;
    localparam int OFF_W = LOG_N;
    localparam int NODES = 2 * TOTAL_BLOCKS - 1;

    localparam logic [VAL_W-1:0] N_VAL    = VAL_W'(TOTAL_BLOCKS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);
    localparam logic [IDX_W-1:0] LEAF0    = IDX_W'(TOTAL_BLOCKS - 1);
    localparam logic [31:0]      BYTE_MASK = 32'((64'd1 << BLOCK_SIZE_EXP) - 64'd1);

    // Longest free run below each node.
    logic [VAL_W-1:0] mem [NODES];

    t_state           r_state, n_state;
    logic [63:0]      r_base;
    logic             r_op, n_op;
    logic [31:0]      r_bytes, n_bytes;
    logic [63:0]      r_addr, n_addr;
    logic [VAL_W-1:0] r_blocks, n_blocks;
    logic [VAL_W-1:0] r_want, n_want;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [VAL_W-1:0] r_size, n_size;
    logic [VAL_W-1:0] r_val, n_val;
    logic [OFF_W-1:0] r_off, n_off;
    t_status          r_res_status, n_res_status;
    logic             r_out_valid, n_out_valid;
    t_status          r_out_status, n_out_status;
    logic [63:0]      r_out_addr, n_out_addr;
    logic [IDX_W-1:0] r_clr_idx, n_clr_idx;
    logic [VAL_W-1:0] r_clr_span, n_clr_span;
    logic [VAL_W-1:0] r_rd;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic [IDX_W-1:0] rd_addr;

    // Request preprocessing.
    logic [32:0]      blocks_full;
    logic             oversize;
    logic [63:0]      addr_diff;
    logic [63:0]      off_full;
    logic             out_range;
    logic [IDX_W-1:0] leaf_idx;
    logic [VAL_W-1:0] blocks_m1;
    logic [VAL_W-1:0] want_pow2;

    // Tree walk helpers.
    logic [IDX_W-1:0] left_idx, right_idx, parent_idx, sib_idx;
    logic [IDX_W-1:0] down_idx, down_left;
    logic [VAL_W-1:0] down_size;
    logic [OFF_W-1:0] down_off;
    logic             go_left;
    logic [VAL_W-1:0] up_l, up_r, up_max, up_size, up_val;
    logic [VAL_W:0]   up_sum;
    logic [IDX_W-1:0] par_sib;
    logic [IDX_W-1:0] clr_nxt;
    logic [IDX_W:0]   clr_nxt1;

    always_comb begin
        blocks_full = {1'b0, r_bytes >> BLOCK_SIZE_EXP} + 33'(|(r_bytes & BYTE_MASK));
        oversize    = blocks_full > 33'(TOTAL_BLOCKS);
        addr_diff   = r_addr - r_base;
        off_full    = addr_diff >> BLOCK_SIZE_EXP;
        out_range   = off_full >= 64'(TOTAL_BLOCKS);
        leaf_idx    = LEAF0 + IDX_W'(off_full[OFF_W-1:0]);

        // Round the block count up to a power of two: one above the top set
        // bit of count minus one.
        blocks_m1 = r_blocks - VAL_W'(1);
        want_pow2 = VAL_W'(1);
        for (int b = 0; b < VAL_W; b++) begin
            if (blocks_m1[b]) begin
                want_pow2 = VAL_W'(2) << b;
            end
        end
    end

    always_comb begin
        left_idx   = {r_idx[IDX_W-2:0], 1'b1};
        right_idx  = left_idx + IDX_W'(1);
        parent_idx = (r_idx - IDX_W'(1)) >> 1;
        sib_idx    = r_idx[0] ? r_idx + IDX_W'(1) : r_idx - IDX_W'(1);
        par_sib    = parent_idx[0] ? parent_idx + IDX_W'(1) : parent_idx - IDX_W'(1);

        // One level of descent: r_rd holds the left child of r_idx.
        go_left   = r_rd >= r_want;
        down_idx  = go_left ? left_idx : right_idx;
        down_size = r_size >> 1;
        down_off  = go_left ? r_off : (r_off | OFF_W'(down_size));
        down_left = {down_idx[IDX_W-2:0], 1'b1};

        // One level of ascent: r_val is r_idx's value, r_rd its sibling's.
        up_l    = r_idx[0] ? r_val : r_rd;
        up_r    = r_idx[0] ? r_rd : r_val;
        up_max  = (up_l > up_r) ? up_l : up_r;
        up_size = r_size << 1;
        up_sum  = {1'b0, up_l} + {1'b0, up_r};
        up_val  = ((r_op == OP_FREE) && (up_sum == {1'b0, up_size})) ? up_size : up_max;

        clr_nxt  = r_clr_idx + IDX_W'(1);
        clr_nxt1 = {1'b0, clr_nxt} + (IDX_W + 1)'(1);
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_bytes      = r_bytes;
        n_addr       = r_addr;
        n_blocks     = r_blocks;
        n_want       = r_want;
        n_idx        = r_idx;
        n_size       = r_size;
        n_val        = r_val;
        n_off        = r_off;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;
        n_clr_idx    = r_clr_idx;
        n_clr_span   = r_clr_span;
        mem_we       = 1'b0;
        mem_waddr    = r_idx;
        mem_wdata    = r_val;
        rd_addr      = '0;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_idx;
                mem_wdata = r_clr_span;
                n_clr_idx = clr_nxt;
                // A new tree level starts where the node number plus one is a
                // power of two.
                if (({1'b0, clr_nxt} & clr_nxt1) == '0) begin
                    n_clr_span = r_clr_span >> 1;
                end
                if (r_clr_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_operation;
                    n_bytes = i_request_bytes;
                    n_addr  = i_free_address;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (r_op == OP_ALLOC) begin
                    if ((r_bytes == 32'd0) || oversize) begin
                        n_res_status = ST_BAD_SIZE;
                        n_state      = S_DONE;
                    end else begin
                        n_blocks = blocks_full[VAL_W-1:0];
                        n_state  = S_SIZE;
                    end
                end else begin
                    if (out_range) begin
                        n_res_status = ST_RANGE;
                        n_state      = S_DONE;
                    end else begin
                        n_idx   = leaf_idx;
                        n_size  = VAL_W'(1);
                        rd_addr = leaf_idx;
                        n_state = S_FUP;
                    end
                end
            end
            S_SIZE: begin
                n_want  = want_pow2;
                rd_addr = '0;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                if (r_rd < r_want) begin
                    n_res_status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    n_idx  = '0;
                    n_size = N_VAL;
                    n_off  = '0;
                    n_val  = '0;
                    if (N_VAL > r_want) begin
                        rd_addr = IDX_W'(1);
                        n_state = S_DOWN;
                    end else begin
                        n_state = S_MARK;
                    end
                end
            end
            S_DOWN: begin
                n_idx  = down_idx;
                n_size = down_size;
                n_off  = down_off;
                if (down_size > r_want) begin
                    rd_addr = down_left;
                end else begin
                    n_val   = '0;
                    n_state = S_MARK;
                end
            end
            S_FUP: begin
                if (r_rd == '0) begin
                    n_val   = r_size;
                    n_state = S_MARK;
                end else if (r_idx == '0) begin
                    // Climbed to the root without meeting a used node.
                    n_res_status = ST_OK;
                    n_state      = S_DONE;
                end else begin
                    n_idx   = parent_idx;
                    n_size  = r_size << 1;
                    rd_addr = parent_idx;
                end
            end
            S_MARK: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = r_val;
                if (r_idx == '0) begin
                    n_res_status = ST_OK;
                    n_state      = S_DONE;
                end else begin
                    rd_addr = sib_idx;
                    n_state = S_UP;
                end
            end
            S_UP: begin
                mem_we    = 1'b1;
                mem_waddr = parent_idx;
                mem_wdata = up_val;
                n_idx     = parent_idx;
                n_val     = up_val;
                n_size    = up_size;
                if (parent_idx == '0) begin
                    n_res_status = ST_OK;
                    n_state      = S_DONE;
                end else begin
                    rd_addr = par_sib;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    if ((r_op == OP_ALLOC) && (r_res_status == ST_OK)) begin
                        n_out_addr = r_base + (64'(r_off) << BLOCK_SIZE_EXP);
                    end else begin
                        n_out_addr = 64'd0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= 64'd0;
            r_out_valid <= 1'b0;
            r_clr_idx   <= '0;
            r_clr_span  <= N_VAL;
        end else begin
            if (i_base_address_we) begin
                r_base <= i_base_address;
            end
            r_out_valid <= n_out_valid;
            r_clr_idx   <= n_clr_idx;
            r_clr_span  <= n_clr_span;
        end
        r_op         <= n_op;
        r_bytes      <= n_bytes;
        r_addr       <= n_addr;
        r_blocks     <= n_blocks;
        r_want       <= n_want;
        r_idx        <= n_idx;
        r_size       <= n_size;
        r_val        <= n_val;
        r_off        <= n_off;
        r_res_status <= n_res_status;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= mem[rd_addr];
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_granted_address = r_out_addr;

`include "buddy_allocator_tree_assert.svh"

    `BAT_IMPLY(a_mark_size, (r_state == S_MARK) && (r_op == OP_ALLOC), r_size == r_want, "alloc marked a node of the wrong size")
    `BAT_IMPLY(a_write_range, mem_we, mem_waddr <= LAST_IDX, "tree write beyond last node")
    `BAT_IMPLY(a_fail_no_addr, o_out_valid && (o_status != ST_OK), o_granted_address == 64'd0, "failed request carries an address")
    `BAT_IMPLY(a_walk_size, (r_state == S_DOWN) || (r_state == S_FUP) || (r_state == S_UP), $onehot(r_size), "node size is not a power of two")
    `BAT_NEXT(a_accept_busy, i_in_valid && !o_in_stall, o_in_stall, "second beat taken while busy")

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import buddy_pkg::*;

    localparam int TOTAL_BLOCKS   = 256;
    localparam int BLOCK_SIZE_EXP = 12;
    localparam int NODES          = 2 * TOTAL_BLOCKS - 1;
    localparam int BLOCK_BYTES    = 1 << BLOCK_SIZE_EXP;
    localparam int REGION_BYTES   = TOTAL_BLOCKS * BLOCK_BYTES;
    // The limit covers the slowest correct run, about 700 requests plus idle gaps
    // on both sides and the clearing pass after reset, with a wide margin on top.
    localparam int CYCLE_LIMIT    = 400000;

    // One allocated run as seen by the stimulus: first block and length.
    typedef struct packed {
        int unsigned first_block;
        int unsigned blocks;
    } t_live_run;

    // Predicts status and granted address for every accepted request beat,
    // and keeps its own copy of the longest-free-run tree and base address.
    class t_alloc_tracker;
        logic [8:0]  longest_free [NODES];
        logic [63:0] base_addr;
        t_status     pending_status [$];
        logic [63:0] pending_grant [$];
        int          errors;
        int          checked;
        int          grants;
        int          status_seen [4];
        bit          last_granted;
        int unsigned last_offset;
        int unsigned last_blocks;
        int          last_freed;

        function new();
            int unsigned span;
            span = 2 * TOTAL_BLOCKS;
            for (int unsigned i = 0; i < NODES; i++) begin
                // The first node of every tree level halves the span.
                if (((i + 1) & i) == 0) span = span >> 1;
                longest_free[i] = span[8:0];
            end
            base_addr = '0;
        endfunction

        function int pending();
            return pending_status.size();
        endfunction

        task report(string msg);
            errors++;
            $display("tb: mismatch: %s", msg);
        endtask

        function void allocate(logic [31:0] bytes, output t_status st,
                               output logic [63:0] grant);
            int unsigned blocks, want, run_len, node, lt, rt;
            st    = ST_OK;
            grant = '0;
            if (bytes == 0) begin
                st = ST_BAD_SIZE;
                return;
            end
            blocks = (bytes >> BLOCK_SIZE_EXP) + ((bytes & (BLOCK_BYTES - 1)) != 0 ? 1 : 0);
            if (blocks > TOTAL_BLOCKS) begin
                st = ST_BAD_SIZE;
                return;
            end
            want = 1;
            while (want < blocks) want = want << 1;
            if (longest_free[0] < want) begin
                st = ST_FULL;
                return;
            end
            node = 0;
            for (run_len = TOTAL_BLOCKS; run_len > want; run_len = run_len >> 1) begin
                if (longest_free[2 * node + 1] >= want) node = 2 * node + 1;
                else node = 2 * node + 2;
            end
            longest_free[node] = '0;
            last_offset  = (node + 1) * run_len - TOTAL_BLOCKS;
            last_blocks  = want;
            last_granted = 1'b1;
            while (node != 0) begin
                node = ((node + 1) >> 1) - 1;
                lt = longest_free[2 * node + 1];
                rt = longest_free[2 * node + 2];
                longest_free[node] = (lt > rt) ? lt[8:0] : rt[8:0];
            end
            grant = base_addr + (64'(last_offset) << BLOCK_SIZE_EXP);
        endfunction

        function void release_addr(logic [63:0] addr, output t_status st);
            logic [63:0] rel;
            int unsigned node, run_len, lt, rt;
            bit          found;
            rel = (addr - base_addr) >> BLOCK_SIZE_EXP;
            if (rel >= TOTAL_BLOCKS) begin
                st = ST_RANGE;
                return;
            end
            st        = ST_OK;
            node      = rel[31:0] + TOTAL_BLOCKS - 1;
            run_len   = 1;
            found     = 1'b1;
            // Climb from the leaf to the first node marked used.
            while (found && longest_free[node] != 0) begin
                if (node == 0) begin
                    found = 1'b0;
                end else begin
                    run_len = run_len << 1;
                    node = ((node + 1) >> 1) - 1;
                end
            end
            if (!found) return;
            last_freed = (node + 1) * run_len - TOTAL_BLOCKS;
            longest_free[node] = run_len[8:0];
            // Merge buddies on the way back to the root.
            while (node != 0) begin
                node = ((node + 1) >> 1) - 1;
                run_len = run_len << 1;
                lt = longest_free[2 * node + 1];
                rt = longest_free[2 * node + 2];
                if (lt + rt == run_len) longest_free[node] = run_len[8:0];
                else longest_free[node] = (lt > rt) ? lt[8:0] : rt[8:0];
            end
        endfunction

        function void take_request(logic op, logic [31:0] bytes, logic [63:0] addr);
            t_status     st;
            logic [63:0] grant;
            last_granted = 1'b0;
            last_freed   = -1;
            grant        = '0;
            if (op == OP_ALLOC) allocate(bytes, st, grant);
            else release_addr(addr, st);
            if (last_granted) grants++;
            status_seen[st]++;
            pending_status.push_back(st);
            pending_grant.push_back(grant);
        endfunction

        task match_reply(t_status st, logic [63:0] grant);
            t_status     exp_st;
            logic [63:0] exp_grant;
            if (pending_status.size() == 0) begin
                report($sformatf("reply beat status %0d address %h with no request open",
                                 st, grant));
                return;
            end
            exp_st    = pending_status.pop_front();
            exp_grant = pending_grant.pop_front();
            checked++;
            if (st !== exp_st)
                report($sformatf("reply %0d status %0d, predicted %0d", checked, st, exp_st));
            if (grant !== exp_grant)
                report($sformatf("reply %0d address %h, predicted %h",
                                 checked, grant, exp_grant));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_base_address_we;
    logic [63:0]        i_base_address;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_operation;
    logic [31:0]        i_request_bytes;
    logic [63:0]        i_free_address;
    logic               o_out_valid;
    logic               i_out_stall;
    t_status            o_status;
    logic [63:0]        o_granted_address;

    t_alloc_tracker tracker = new();
    t_live_run      live_runs [$];
    bit             calm;
    int             cycles;
    int             requests;

    buddy_allocator_tree #(
        .TOTAL_BLOCKS   (TOTAL_BLOCKS),
        .BLOCK_SIZE_EXP (BLOCK_SIZE_EXP)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_base_address_we (i_base_address_we),
        .i_base_address    (i_base_address),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_operation       (i_operation),
        .i_request_bytes   (i_request_bytes),
        .i_free_address    (i_free_address),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_granted_address (o_granted_address)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run guard: a hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Reply side. Signals are read right after the edge, so they still hold
    // the values that the edge itself saw. A beat moves when valid was high
    // and our stall was low. The stall is redrawn every cycle, except in the
    // calm stretch where the receiver never holds back.
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
                tracker.match_reply(o_status, o_granted_address);
            i_out_stall <= !calm && ($urandom_range(0, 99) < 28);
        end
    end

    // Presents one request beat and holds it until the block takes it. Idle
    // cycles come first and are drawn before valid rises, so they never depend
    // on the stall. When the beat is taken, the prediction is made at once and
    // the list of live runs follows what the tree now holds.
    task automatic send(logic op, logic [31:0] bytes, logic [63:0] addr);
        while (!calm && $urandom_range(0, 99) < 28) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_operation     <= op;
        i_request_bytes <= bytes;
        i_free_address  <= addr;
        forever begin
            @(posedge i_clk);
            if (o_in_stall === 1'b0) break;
        end
        requests++;
        tracker.take_request(op, bytes, addr);
        if (tracker.last_granted)
            live_runs.push_back('{tracker.last_offset, tracker.last_blocks});
        if (tracker.last_freed >= 0) begin
            for (int i = 0; i < live_runs.size(); i++) begin
                if (live_runs[i].first_block == tracker.last_freed) begin
                    live_runs.delete(i);
                    break;
                end
            end
        end
    endtask

    // The field that the operation ignores still carries random bits.
    task automatic send_alloc(logic [31:0] bytes);
        send(OP_ALLOC, bytes, {$urandom, $urandom});
    endtask

    task automatic send_free(logic [63:0] addr);
        send(OP_FREE, $urandom, addr);
    endtask

    // Changes the base address only once every reply is in and the block is
    // ready for a new beat, so no request can be in flight during the write.
    task automatic set_base(logic [63:0] value);
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0 || o_in_stall !== 1'b0) @(posedge i_clk);
        i_base_address_we <= 1'b1;
        i_base_address    <= value;
        @(posedge i_clk);
        i_base_address_we <= 1'b0;
        tracker.base_addr = value;
    endtask

    // Mostly well-formed traffic: allocations of mostly small sizes and frees
    // of runs that are really live, somewhere inside the run. The rest is
    // noise: random and zero sizes, random addresses, frees of blocks that
    // may be free, and addresses just below or past the region.
    task automatic random_item();
        int unsigned pick, size_pick, blocks;
        logic [63:0] addr;
        t_live_run   run;
        pick = $urandom_range(0, 99);
        if (pick < 45 || (pick < 80 && live_runs.size() == 0)) begin
            size_pick = $urandom_range(0, 99);
            if (size_pick < 70) blocks = $urandom_range(1, 8);
            else if (size_pick < 95) blocks = $urandom_range(9, 64);
            else blocks = $urandom_range(65, TOTAL_BLOCKS);
            send_alloc((blocks - 1) * BLOCK_BYTES + $urandom_range(1, BLOCK_BYTES));
        end else if (pick < 80) begin
            run  = live_runs[$urandom_range(0, live_runs.size() - 1)];
            addr = tracker.base_addr
                 + (64'(run.first_block + $urandom_range(0, run.blocks - 1)) << BLOCK_SIZE_EXP);
            if ($urandom_range(0, 1) == 1) addr = addr + $urandom_range(0, BLOCK_BYTES - 1);
            send_free(addr);
        end else begin
            case ($urandom_range(0, 5))
                0: send_alloc($urandom);
                1: send_alloc(32'd0);
                2: send_free({$urandom, $urandom});
                3: send_free(tracker.base_addr
                             + (64'($urandom_range(0, TOTAL_BLOCKS - 1)) << BLOCK_SIZE_EXP));
                4: send_free(tracker.base_addr - $urandom_range(1, 2 * BLOCK_BYTES));
                default: send_free(tracker.base_addr + REGION_BYTES
                                   + $urandom_range(0, REGION_BYTES));
            endcase
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_base_address_we <= 1'b0;
        i_base_address    <= '0;
        i_in_valid        <= 1'b0;
        i_operation       <= OP_ALLOC;
        i_request_bytes   <= '0;
        i_free_address    <= '0;
        calm      = 1'b0;
        cycles    = 0;
        requests  = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The block clears its tree after reset and holds the stall high until
        // it is done; set_base waits for that before writing.
        set_base(64'd0);

        // Directed requests on an empty region with a zero base.
        send_alloc(32'd0);                   // zero request
        send_alloc(32'hFFFF_FFFF);           // largest byte count, far oversize
        send_alloc(REGION_BYTES + 1);        // one byte past the region
        send_alloc(REGION_BYTES);            // exactly the whole region
        send_alloc(32'd1);                   // nothing left: region full
        send_free(64'h0000_0000_0000_0FFF);  // low bits inside block 0 free it all
        send_free(64'd0);                    // run no longer allocated
        send_free(64'hFFFF_FFFF_FFFF_FFFF);  // below the base, wraps far out
        send_free(64'(REGION_BYTES));        // first byte past the region
        send_alloc(32'd1);                   // one block at block 0
        send_alloc(BLOCK_BYTES + 1);         // two blocks at block 2
        send_alloc(3 * BLOCK_BYTES + 1);     // rounds up to four, at block 4
        send_alloc(BLOCK_BYTES);             // fills the hole at block 1
        send_free(64'(6 * BLOCK_BYTES + 12'hABC)); // middle of the four-block run
        send_alloc(4 * BLOCK_BYTES);         // reuses blocks 4 to 7
        send_alloc(REGION_BYTES / 2);        // the whole right half
        send_alloc(REGION_BYTES / 2);        // left half is partly used: full
        send_free(64'(REGION_BYTES / 2));
        send_free(64'd0);
        send_free(64'(BLOCK_BYTES));
        send_free(64'(2 * BLOCK_BYTES));
        send_free(64'(4 * BLOCK_BYTES));

        repeat (200) random_item();

        // Unaligned base at the top of the address space: every grant past block 0 wraps.
        set_base(64'hFFFF_FFFF_FFFF_FFFF);
        send_free(64'hFFFF_FFFF_FFFF_FFFE);  // one byte below the base
        repeat (150) random_item();

        // Region ends exactly at the top of memory. Neither side idles here.
        set_base(64'hFFFF_FFFF_FFF0_0000);
        calm = 1'b1;
        repeat (150) random_item();
        calm = 1'b0;

        set_base({$urandom, $urandom});
        repeat (150) random_item();

        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        // A stray extra reply would show up in this wait, which outlasts any request.
        repeat (40) @(posedge i_clk);

        $display("tb: %0d requests, %0d replies checked, %0d grants, %0d live runs left",
                 requests, tracker.checked, tracker.grants, live_runs.size());
        $display("tb: statuses ok %0d, bad size %0d, full %0d, out of range %0d; four bases",
                 tracker.status_seen[ST_OK], tracker.status_seen[ST_BAD_SIZE],
                 tracker.status_seen[ST_FULL], tracker.status_seen[ST_RANGE]);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/buddy_pkg.sv
sv/buddy_allocator_tree.sv
tb/tb.sv
